// ===== src/bcu_pkg.sv =====
package bcu_pkg;

  // default field widths
  localparam int unsigned NBitsDef      = 8;
  localparam int unsigned ResultBitsDef = 64;

  // quotient bits produced per divider cycle
  localparam int unsigned DigitBits = 4;

  // padded width of the product / dividend word, a multiple of DigitBits
  function automatic int unsigned prod_width(input int unsigned n_bits,
                                             input int unsigned res_bits);
    int unsigned w;
    w = n_bits + res_bits;
    return ((w + DigitBits - 1) / DigitBits) * DigitBits;
  endfunction

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StDiv  = 5'b00100,
    StFin  = 5'b01000,
    StOut  = 5'b10000
  } bcu_state_e;

endpackage

// ===== src/binomial_coefficient_unit.sv =====
// channel | signals                                             | dir    | transaction
// in      | in_valid_i, in_ready_o, n_i, k_i                    | input  | one (n, k) pair
// out     | out_valid_o, out_ready_i, coefficient_o, overflow_o | output | one C(n,k) result
//
// one transaction in flight; in_ready_o rises together with out_valid_o, and the work runs
//   s = min(k, n-k) steps, or fewer when the step loop quits at the first value past RESULT_BITS,
// each step running the bit-serial multiplier and then the radix-16 divider once
// k > n and b = 0 skip the steps and go straight to StFin
// reset (rst_ni low, asynchronous) returns the controller to idle, no result pending
// a stalled output holds the finished result; the next item is still taken and worked on,
// and its result waits in StOut until the output register is free
module binomial_coefficient_unit #(
  parameter int unsigned N_BITS      = bcu_pkg::NBitsDef,
  parameter int unsigned RESULT_BITS = bcu_pkg::ResultBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [N_BITS-1:0]      n_i,
  input  logic [N_BITS-1:0]      k_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [RESULT_BITS-1:0] coefficient_o,
  output logic                   overflow_o
);
  import bcu_pkg::*;

  localparam int unsigned ProdW = prod_width(N_BITS, RESULT_BITS);

  bcu_state_e state_q, state_d;

  // step registers: running value C(n, j-1), falling top value, step index
  logic [RESULT_BITS-1:0] acc_q, acc_d;
  logic [N_BITS-1:0]      top_q, top_d;
  logic [N_BITS-1:0]      j_q, j_d;
  logic [N_BITS-1:0]      b_q, b_d;
  logic                   ovf_q, ovf_d;

  // start pulses are registered so the units latch the updated step registers
  logic mul_start_q, mul_start_d;
  logic div_start_q, div_start_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [RESULT_BITS-1:0] coef_q, coef_d;
  logic                   ovf_out_q, ovf_out_d;

  logic                   mul_done;
  logic [ProdW-1:0]       prod;
  logic                   div_done;
  logic [ProdW-1:0]       quot;
  logic [N_BITS-1:0]      n_minus_k;
  logic [N_BITS-1:0]      b_new;
  logic                   in_fire;
  logic                   out_free;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign n_minus_k  = n_i - k_i;
  assign b_new      = (k_i > n_minus_k) ? n_minus_k : k_i;

  bcu_mul #(
    .N_BITS      (N_BITS),
    .RESULT_BITS (RESULT_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .acc_i   (acc_q),
    .top_i   (top_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // exact division of acc * top by j
  bcu_div #(
    .N_BITS      (N_BITS),
    .RESULT_BITS (RESULT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (prod),
    .divisor_i  (j_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    top_d       = top_q;
    j_d         = j_q;
    b_d         = b_q;
    ovf_d       = ovf_q;
    mul_start_d = 1'b0;
    div_start_d = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    coef_d      = coef_q;
    ovf_out_d   = ovf_out_q;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          ovf_d = 1'b0;
          top_d = n_i;
          j_d   = {{(N_BITS-1){1'b0}}, 1'b1};
          b_d   = b_new;
          if (k_i > n_i) begin
            // empty choice: result is zero
            acc_d   = '0;
            state_d = StFin;
          end else begin
            acc_d = {{(RESULT_BITS-1){1'b0}}, 1'b1};
            if (b_new == '0) begin
              state_d = StFin;
            end else begin
              mul_start_d = 1'b1;
              state_d     = StMul;
            end
          end
        end
      end
      StMul: begin
        if (mul_done) begin
          div_start_d = 1'b1;
          state_d     = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          state_d = StFin;
          // C(n,j) grows with j up to b, so any excess is final
          if (quot[ProdW-1:RESULT_BITS] != '0) begin
            ovf_d = 1'b1;
          end else begin
            acc_d = quot[RESULT_BITS-1:0];
            if (j_q != b_q) begin
              j_d         = j_q + 1'b1;
              top_d       = top_q - 1'b1;
              mul_start_d = 1'b1;
              state_d     = StMul;
            end
          end
        end
      end
      StFin: begin
        state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          coef_d      = ovf_q ? '1 : acc_q;
          ovf_out_d   = ovf_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mul_start_q <= mul_start_d;
      div_start_q <= div_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    top_q     <= top_d;
    j_q       <= j_d;
    b_q       <= b_d;
    ovf_q     <= ovf_d;
    coef_q    <= coef_d;
    ovf_out_q <= ovf_out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef_q;
  assign overflow_o    = ovf_out_q;

endmodule

// ===== src/bcu_mul.sv =====
module bcu_mul #(
  parameter int unsigned N_BITS      = bcu_pkg::NBitsDef,
  parameter int unsigned RESULT_BITS = bcu_pkg::ResultBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [RESULT_BITS-1:0] acc_i,
  input  logic [N_BITS-1:0]     top_i,
  output logic                  done_o,
  output logic [bcu_pkg::prod_width(N_BITS, RESULT_BITS)-1:0] prod_o
);
  import bcu_pkg::*;

  localparam int unsigned ProdW = prod_width(N_BITS, RESULT_BITS);
  localparam int unsigned CntW  = $clog2(N_BITS);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [N_BITS-1:0]      top_sr_q, top_sr_d;
  logic [RESULT_BITS-1:0] acc_q, acc_d;
  logic [ProdW-1:0]       prod_q, prod_d;

  // msb-first shift-add, one multiplier bit per cycle
  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    top_sr_d = top_sr_q;
    acc_d    = acc_q;
    prod_d   = prod_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = CntW'(N_BITS - 1);
      top_sr_d = top_i;
      acc_d    = acc_i;
      prod_d   = '0;
    end else if (busy_q) begin
      prod_d   = {prod_q[ProdW-2:0], 1'b0}
                 + (top_sr_q[N_BITS-1] ? ProdW'(acc_q) : '0);
      top_sr_d = {top_sr_q[N_BITS-2:0], 1'b0};
      cnt_d    = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_sr_q <= top_sr_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ===== src/bcu_div.sv =====
module bcu_div #(
  parameter int unsigned N_BITS      = bcu_pkg::NBitsDef,
  parameter int unsigned RESULT_BITS = bcu_pkg::ResultBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [bcu_pkg::prod_width(N_BITS, RESULT_BITS)-1:0] dividend_i,
  input  logic [N_BITS-1:0] divisor_i,
  output logic              done_o,
  output logic [bcu_pkg::prod_width(N_BITS, RESULT_BITS)-1:0] quot_o
);
  import bcu_pkg::*;

  localparam int unsigned ProdW = prod_width(N_BITS, RESULT_BITS);
  localparam int unsigned Steps = ProdW / DigitBits;
  localparam int unsigned CntW  = $clog2(Steps);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ProdW-1:0]  sr_q, sr_d;     // dividend out at the top, quotient in at the bottom
  logic [N_BITS-1:0] rem_q, rem_d;
  logic [N_BITS-1:0] dsr_q, dsr_d;
  logic [ProdW-1:0]  sr_step;
  logic [N_BITS-1:0] rem_step;

  // restoring division, DigitBits quotient bits per cycle on a narrow remainder
  always_comb begin : digit_step
    logic [N_BITS:0] r;
    logic            qb;
    sr_step  = sr_q;
    rem_step = rem_q;
    for (int unsigned i = 0; i < DigitBits; i++) begin
      r  = {rem_step, sr_step[ProdW-1]};
      qb = (r >= {1'b0, dsr_q});
      if (qb) r = r - {1'b0, dsr_q};
      rem_step = r[N_BITS-1:0];
      sr_step  = {sr_step[ProdW-2:0], qb};
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sr_d   = sr_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Steps - 1);
      sr_d   = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      sr_d  = sr_step;
      rem_d = rem_step;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q  <= sr_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = sr_q;

endmodule
